// File: src/tmrtbl_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, field widths and codes shared by the timer table logic.
// ----------------------------------------------------------------------------
package tmrtbl_pkg;

  // table geometry
  localparam int unsigned SLOTS       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W       = $clog2(SLOTS + 1);
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ELAPSE_W = 16;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned FLAG_W   = 2;
  localparam int unsigned FRAC_W   = 8;   // Q8.8 scale

  // configuration port
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;  // 1.0

  // entry flag bits
  localparam int unsigned FLAG_REPEAT_BIT = 0;
  localparam int unsigned FLAG_FIRED_BIT  = 1;

  // input word operation
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_ONESHOT = 2'd1,
    MODE_REPEAT  = 2'd2
  } mode_e;

  // result word kind
  typedef enum logic [KIND_W-1:0] {
    KIND_QUIET = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_ADDED = 2'd2,
    KIND_FULL  = 2'd3
  } kind_e;

endpackage

// File: src/delayed_and_repeating_timer_table.sv
// ----------------------------------------------------------------------------
// Delayed and repeating timer table
// Packed table of one-shot and periodic timers, advanced by scaled ticks.
// ----------------------------------------------------------------------------
// An add word (one-shot or repeating) or an unused mode code keeps busy low,
// and its single result word appears on the cycle after start. A tick word
// holds busy high through a scaling step, in which the shared 16x16 multiply
// scales elapsed time, a walk over every table entry through a single
// saturating adder and comparator, which also closes up the table in place,
// and a closing step. Fired handles leave in table order, one word per cycle
// at most, and the final word carries last. Result words are shown for one
// cycle only and cannot be held off.
module delayed_and_repeating_timer_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic [tmrtbl_pkg::MODE_W-1:0]    mode_i,
  input  logic [tmrtbl_pkg::ELAPSE_W-1:0]  elapsed_ms_i,
  input  logic [tmrtbl_pkg::TIME_W-1:0]    first_delay_ms_i,
  input  logic [tmrtbl_pkg::TIME_W-1:0]    period_ms_i,
  input  logic [tmrtbl_pkg::HANDLE_W-1:0]  handle_i,
  // result side
  output logic                             valid_o,
  output logic [tmrtbl_pkg::KIND_W-1:0]    kind_o,
  output logic [tmrtbl_pkg::HANDLE_W-1:0]  fired_handle_o,
  output logic [tmrtbl_pkg::TIME_W-1:0]    scaled_delta_o,
  output logic                             last_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tmrtbl_pkg::ADDR_W-1:0]    paddr,
  input  logic [tmrtbl_pkg::DATA_W-1:0]    pwdata,
  output logic [tmrtbl_pkg::DATA_W-1:0]    prdata,
  output logic                             pready
);
  import tmrtbl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_WALK
  } state_e;

  // entry storage
  logic [TIME_W-1:0]   waited_mem [SLOTS];
  logic [TIME_W-1:0]   first_mem  [SLOTS];
  logic [TIME_W-1:0]   period_mem [SLOTS];
  logic [HANDLE_W-1:0] handle_mem [SLOTS];
  logic [FLAG_W-1:0]   flags_mem  [SLOTS];

  // control and payload registers
  state_e               state_q;
  logic [SCALE_W-1:0]   scale_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     rd_q;
  logic [CNT_W-1:0]     wr_q;
  logic [RES_W-1:0]     nres_q;
  logic [ELAPSE_W-1:0]  elapsed_q;
  logic [TIME_W-1:0]    delta_q;
  logic                 pend_q;
  logic [HANDLE_W-1:0]  pend_handle_q;
  logic                 valid_q;
  kind_e                kind_q;
  logic [HANDLE_W-1:0]  fired_handle_q;
  logic [TIME_W-1:0]    scaled_delta_q;
  logic                 last_q;

  // handshakes
  logic accept;
  logic cfg_wr;
  logic cfg_hit;
  assign accept  = start && (state_q == ST_IDLE);
  assign cfg_hit = (paddr[ADDR_W-1] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;

  assign busy   = (state_q != ST_IDLE);
  assign pready = 1'b1;
  assign prdata = cfg_hit ? {{(DATA_W-SCALE_W){1'b0}}, scale_q} : '0;

  assign valid_o        = valid_q;
  assign kind_o         = kind_q;
  assign fired_handle_o = fired_handle_q;
  assign scaled_delta_o = scaled_delta_q;
  assign last_o         = last_q;

  // shared multiplier: elapsed time by Q8.8 scale, fits after the shift
  logic [ELAPSE_W+SCALE_W-1:0] prod;
  assign prod = elapsed_q * scale_q;

  // current entry through the shared adder and comparator
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    add_idx;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   w_sat;
  logic [TIME_W-1:0]   thr;
  logic [FLAG_W-1:0]   rd_flags;
  logic                fire;
  logic                keep;
  logic                walk_end;

  assign rd_idx   = rd_q[IDX_W-1:0];
  assign wr_idx   = wr_q[IDX_W-1:0];
  assign add_idx  = count_q[IDX_W-1:0];
  assign walk_end = (rd_q == count_q);
  assign rd_flags = flags_mem[rd_idx];
  assign sum      = {1'b0, waited_mem[rd_idx]} + {1'b0, delta_q};
  assign w_sat    = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign thr      = rd_flags[FLAG_FIRED_BIT] ? period_mem[rd_idx] : first_mem[rd_idx];
  assign fire     = (w_sat >= thr);
  assign keep     = !fire || rd_flags[FLAG_REPEAT_BIT];

  // table write port: new entry on add, compaction during the walk
  logic                tbl_we;
  logic [IDX_W-1:0]    tbl_addr;
  logic [TIME_W-1:0]   tbl_waited;
  logic [TIME_W-1:0]   tbl_first;
  logic [TIME_W-1:0]   tbl_period;
  logic [HANDLE_W-1:0] tbl_handle;
  logic [FLAG_W-1:0]   tbl_flags;
  logic                add_ok;

  assign add_ok = (count_q < CNT_W'(SLOTS));

  always_comb begin
    tbl_we     = 1'b0;
    tbl_addr   = wr_idx;
    tbl_waited = fire ? '0 : w_sat;
    tbl_first  = first_mem[rd_idx];
    tbl_period = period_mem[rd_idx];
    tbl_handle = handle_mem[rd_idx];
    tbl_flags  = rd_flags;
    if (fire) begin
      tbl_flags[FLAG_FIRED_BIT] = 1'b1;
    end
    if (accept && add_ok &&
        (mode_i == MODE_ONESHOT || mode_i == MODE_REPEAT)) begin
      tbl_we     = 1'b1;
      tbl_addr   = add_idx;
      tbl_waited = '0;
      tbl_first  = first_delay_ms_i;
      tbl_period = period_ms_i;
      tbl_handle = handle_i;
      tbl_flags  = '0;
      tbl_flags[FLAG_REPEAT_BIT] = (mode_i == MODE_REPEAT);
    end else if (state_q == ST_WALK && !walk_end && keep) begin
      tbl_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      waited_mem[tbl_addr] <= tbl_waited;
      first_mem[tbl_addr]  <= tbl_first;
      period_mem[tbl_addr] <= tbl_period;
      handle_mem[tbl_addr] <= tbl_handle;
      flags_mem[tbl_addr]  <= tbl_flags;
    end
  end

  // sequencer, configuration register and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      scale_q        <= SCALE_RESET;
      count_q        <= '0;
      rd_q           <= '0;
      wr_q           <= '0;
      nres_q         <= '0;
      elapsed_q      <= '0;
      delta_q        <= '0;
      pend_q         <= 1'b0;
      pend_handle_q  <= '0;
      valid_q        <= 1'b0;
      kind_q         <= KIND_QUIET;
      fired_handle_q <= '0;
      scaled_delta_q <= '0;
      last_q         <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_wr) begin
        scale_q <= pwdata[SCALE_W-1:0];
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (mode_i)
              MODE_TICK: begin
                elapsed_q <= elapsed_ms_i;
                state_q   <= ST_SCALE;
              end
              MODE_ONESHOT, MODE_REPEAT: begin
                valid_q        <= 1'b1;
                kind_q         <= add_ok ? KIND_ADDED : KIND_FULL;
                fired_handle_q <= '0;
                scaled_delta_q <= '0;
                last_q         <= 1'b1;
                if (add_ok) begin
                  count_q <= count_q + 1'b1;
                end
              end
              default: begin
                // unused code: one quiet word, nothing else changes
                valid_q        <= 1'b1;
                kind_q         <= KIND_QUIET;
                fired_handle_q <= '0;
                scaled_delta_q <= '0;
                last_q         <= 1'b1;
              end
            endcase
          end
        end
        ST_SCALE: begin
          delta_q <= TIME_W'(prod >> FRAC_W);
          rd_q    <= '0;
          wr_q    <= '0;
          nres_q  <= '0;
          pend_q  <= 1'b0;
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (walk_end) begin
            // closing word: held-back handle, or quiet tick
            valid_q        <= 1'b1;
            kind_q         <= pend_q ? KIND_FIRED : KIND_QUIET;
            fired_handle_q <= pend_q ? pend_handle_q : '0;
            scaled_delta_q <= delta_q;
            last_q         <= 1'b1;
            count_q        <= wr_q;
            state_q        <= ST_IDLE;
          end else begin
            rd_q <= rd_q + 1'b1;
            if (keep) begin
              wr_q <= wr_q + 1'b1;
            end
            // one handle is held back so that the final word can carry last
            if (fire && nres_q < RES_W'(MAX_RESULTS)) begin
              if (pend_q) begin
                valid_q        <= 1'b1;
                kind_q         <= KIND_FIRED;
                fired_handle_q <= pend_handle_q;
                scaled_delta_q <= delta_q;
                last_q         <= 1'b0;
              end
              pend_q        <= 1'b1;
              pend_handle_q <= handle_mem[rd_idx];
              nres_q        <= nres_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table testbench
// Drives add, tick and unused-mode words into the timer table, keeps its own
// copy of the table to work out every result word, and checks each result
// word against it. Covers a full table, zero thresholds, close-up after
// one-shot firing, saturating waits and random traffic over several time
// scales and sender gap rates.
// ----------------------------------------------------------------------------
module tb;
  import tmrtbl_pkg::*;

  localparam int unsigned              REG_TIME_SCALE  = 0;
  localparam logic [ADDR_W-1:0]        TIME_SCALE_ADDR = ADDR_W'(4 * REG_TIME_SCALE);
  localparam logic [MODE_W-1:0]        MODE_UNUSED     = 2'd3;
  localparam int                       SETTLE_CYCLES   = 24;
  localparam int                       QUIET_LIMIT     = 1000;
  localparam int                       REPORT_LIMIT    = 10;
  localparam int                       REPEATER_CAP    = 8;

  typedef struct packed {
    kind_e               kind;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delta;
    logic                last;
  } report_t;

  // DUT connections
  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                start            = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   mode_i           = '0;
  logic [ELAPSE_W-1:0] elapsed_ms_i     = '0;
  logic [TIME_W-1:0]   first_delay_ms_i = '0;
  logic [TIME_W-1:0]   period_ms_i      = '0;
  logic [HANDLE_W-1:0] handle_i         = '0;
  logic                valid_o;
  logic [KIND_W-1:0]   kind_o;
  logic [HANDLE_W-1:0] fired_handle_o;
  logic [TIME_W-1:0]   scaled_delta_o;
  logic                last_o;
  logic                psel             = 1'b0;
  logic                penable          = 1'b0;
  logic                pwrite           = 1'b0;
  logic [ADDR_W-1:0]   paddr            = '0;
  logic [DATA_W-1:0]   pwdata           = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // shadow table and configuration
  logic [SCALE_W-1:0]  time_scale_cfg;
  int                  tbl_count;
  logic [TIME_W-1:0]   tbl_waited [SLOTS];
  logic [TIME_W-1:0]   tbl_first  [SLOTS];
  logic [TIME_W-1:0]   tbl_period [SLOTS];
  logic [HANDLE_W-1:0] tbl_handle [SLOTS];
  logic [FLAG_W-1:0]   tbl_flags  [SLOTS];

  report_t             outstanding_reports [$];
  int                  mismatches = 0;
  int                  gap_pct    = 0;
  int                  quiet_cycles;

  delayed_and_repeating_timer_table i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .first_delay_ms_i (first_delay_ms_i),
    .period_ms_i      (period_ms_i),
    .handle_i         (handle_i),
    .valid_o          (valid_o),
    .kind_o           (kind_o),
    .fired_handle_o   (fired_handle_o),
    .scaled_delta_o   (scaled_delta_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string what);
    if (mismatches < REPORT_LIMIT) begin
      $display("ERROR @%0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Append one expected result word to the tail of the outstanding list
  function automatic void queue_report(input report_t r);
    outstanding_reports.insert(outstanding_reports.size(), r);
  endfunction

  // Shadow table: apply one accepted word and queue the result words it causes
  function automatic void apply_word_to_table(input logic [MODE_W-1:0] m,
                                              input logic [ELAPSE_W-1:0] el,
                                              input logic [TIME_W-1:0] fd,
                                              input logic [TIME_W-1:0] pd,
                                              input logic [HANDLE_W-1:0] h);
    report_t           rep;
    report_t           fired [$];
    logic [63:0]       prod;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] w;
    logic [TIME_W-1:0] thr;
    logic [TIME_W:0]   sum;
    logic [FLAG_W-1:0] fl;
    int                wr;
    bit                keep;

    if (m == MODE_ONESHOT || m == MODE_REPEAT) begin
      if (tbl_count >= SLOTS) begin
        rep = '{KIND_FULL, '0, '0, 1'b1};
      end else begin
        fl = '0;
        fl[FLAG_REPEAT_BIT] = (m == MODE_REPEAT);
        tbl_waited[tbl_count] = '0;
        tbl_first[tbl_count]  = fd;
        tbl_period[tbl_count] = pd;
        tbl_handle[tbl_count] = h;
        tbl_flags[tbl_count]  = fl;
        tbl_count++;
        rep = '{KIND_ADDED, '0, '0, 1'b1};
      end
      queue_report(rep);
      return;
    end
    if (m == MODE_UNUSED) begin
      rep = '{KIND_QUIET, '0, '0, 1'b1};
      queue_report(rep);
      return;
    end

    // tick: scale, then walk the table, closing up behind removed one-shots
    prod  = (64'(el) * 64'(time_scale_cfg)) >> FRAC_W;
    delta = (prod > 64'hFFFF_FFFF) ? '1 : prod[TIME_W-1:0];
    wr    = 0;
    for (int rd = 0; rd < tbl_count; rd++) begin
      sum  = {1'b0, tbl_waited[rd]} + {1'b0, delta};
      w    = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      fl   = tbl_flags[rd];
      thr  = fl[FLAG_FIRED_BIT] ? tbl_period[rd] : tbl_first[rd];
      keep = 1'b1;
      if (w >= thr) begin
        if (fired.size() < MAX_RESULTS) begin
          rep = '{KIND_FIRED, tbl_handle[rd], delta, 1'b0};
          fired.insert(fired.size(), rep);
        end
        w = '0;
        fl[FLAG_FIRED_BIT] = 1'b1;
        if (!fl[FLAG_REPEAT_BIT]) keep = 1'b0;
      end
      if (keep) begin
        tbl_waited[wr] = w;
        tbl_first[wr]  = tbl_first[rd];
        tbl_period[wr] = tbl_period[rd];
        tbl_handle[wr] = tbl_handle[rd];
        tbl_flags[wr]  = fl;
        wr++;
      end
    end
    for (int rd = wr; rd < tbl_count; rd++) begin
      tbl_waited[rd] = '0;
      tbl_flags[rd]  = '0;
    end
    tbl_count = wr;

    if (fired.size() == 0) begin
      rep = '{KIND_QUIET, '0, delta, 1'b1};
      queue_report(rep);
    end else begin
      rep = fired.pop_back();
      rep.last = 1'b1;
      fired.insert(fired.size(), rep);
      foreach (fired[i]) queue_report(fired[i]);
    end
  endfunction

  // Send one word; start stays high on return so a following word goes back to back
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [ELAPSE_W-1:0] el,
                           input logic [TIME_W-1:0] fd, input logic [TIME_W-1:0] pd,
                           input logic [HANDLE_W-1:0] h);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start            <= 1'b1;
    mode_i           <= m;
    elapsed_ms_i     <= el;
    first_delay_ms_i <= fd;
    period_ms_i      <= pd;
    handle_i         <= h;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_word_to_table(m, el, fd, pd, h);
  endtask

  task automatic send_tick(input logic [ELAPSE_W-1:0] el);
    send_word(MODE_TICK, el, $urandom, $urandom, 16'($urandom));
  endtask

  // Stop sending and wait for every outstanding result word
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read back time_scale and compare with the shadow copy
  task automatic check_time_scale();
    logic [DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TIME_SCALE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[SCALE_W-1:0] !== time_scale_cfg) begin
      note_mismatch($sformatf("time_scale read exp %h got %h", time_scale_cfg, rd));
    end
  endtask

  // Change time_scale with the table idle
  task automatic reconfigure(input logic [SCALE_W-1:0] scale);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_write(TIME_SCALE_ADDR, DATA_W'(scale));
    time_scale_cfg = scale;
    @(posedge clk_i);
    check_time_scale();
  endtask

  // Result words: one per strobe, compared with the oldest outstanding one
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (outstanding_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected word kind %0d handle %h delta %h last %b",
                                kind_o, fired_handle_o, scaled_delta_o, last_o));
      end else begin
        want = outstanding_reports.pop_front();
        if (kind_o !== want.kind || fired_handle_o !== want.handle ||
            scaled_delta_o !== want.delta || last_o !== want.last) begin
          note_mismatch($sformatf(
            "exp kind %0d handle %h delta %h last %b, got kind %0d handle %h delta %h last %b",
            want.kind, want.handle, want.delta, want.last,
            kind_o, fired_handle_o, scaled_delta_o, last_o));
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no word moving anywhere
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || valid_o === 1'b1 || (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("delayed_and_repeating_timer_table: mismatch");
    $finish;
  end

  task automatic test_reset_value();
    check_time_scale();
  endtask

  // Fill with zero-delay one-shots, refuse two more, then a zero-delta tick fires all
  task automatic test_full_table();
    logic [HANDLE_W-1:0] h;
    for (int i = 0; i < SLOTS; i++) begin
      h = (i == 0) ? '0 : (i == 1) ? '1 : 16'($urandom);
      send_word(MODE_ONESHOT, 16'($urandom), '0, $urandom, h);
    end
    send_word(MODE_REPEAT, '1, '1, '1, '1);
    send_word(MODE_ONESHOT, '0, '0, '0, '0);
    send_tick('0);
  endtask

  // Unused mode code changes nothing; a tick on the empty table reports its delta
  task automatic test_unused_mode();
    send_word(MODE_UNUSED, '1, '1, '1, '1);
    send_tick('1);
  endtask

  // One-shot with a zero period: the period is never looked at
  task automatic test_one_shot_period();
    send_word(MODE_ONESHOT, '0, 32'd5, '0, 16'h1234);
    send_tick(16'd4);
    send_tick(16'd1);
    send_tick(16'd100);
  endtask

  // Mixed entries: a tail one-shot and then the head one-shot are removed
  task automatic test_close_up();
    send_word(MODE_ONESHOT, '0, 32'd100, 32'd7, 16'hA001);
    send_word(MODE_REPEAT,  '0, 32'd0,   32'd30, 16'hB002);
    send_word(MODE_ONESHOT, '0, 32'd10,  32'd0, 16'hC003);
    send_tick(16'd10);
    send_tick(16'd30);
    send_tick(16'd60);
  endtask

  // Largest scale and elapsed time push a maximal threshold into wait saturation
  task automatic test_saturating_wait();
    reconfigure('1);
    gap_pct = 0;
    send_word(MODE_REPEAT, '0, '1, '1, 16'h5A5A);
    repeat (260) send_tick('1);
  endtask

  // Random traffic under one time scale and sender gap rate
  task automatic run_phase(input int pct, input logic [SCALE_W-1:0] scale, input int words);
    int                  r;
    int                  reps;
    logic [MODE_W-1:0]   m;
    logic [ELAPSE_W-1:0] el;
    logic [TIME_W-1:0]   fd;
    logic [TIME_W-1:0]   pd;
    logic [HANDLE_W-1:0] h;
    reconfigure(scale);
    gap_pct = pct;
    repeat (words) begin
      // now and then hold off until the block has answered everything
      if ($urandom_range(49) == 0) drain_results();
      reps = 0;
      for (int i = 0; i < tbl_count; i++) reps += tbl_flags[i][FLAG_REPEAT_BIT];
      el = 16'($urandom);
      fd = $urandom;
      pd = $urandom;
      h  = 16'($urandom);
      r  = $urandom_range(99);
      if (r < 45) begin
        m = MODE_TICK;
        r = $urandom_range(99);
        if (r < 75) el = 16'($urandom_range(0, 200));
        else if (r < 82) el = '0;
        else if (r < 86) el = '1;
      end else if (r < 87) begin
        m = (r >= 75 && reps < REPEATER_CAP) ? MODE_REPEAT : MODE_ONESHOT;
        r = $urandom_range(99);
        if (r < 10) fd = '0;
        else if (r < 85) fd = $urandom_range(0, 1000);
        else fd = $urandom_range(0, 100000);
        if (m == MODE_REPEAT) begin
          r = $urandom_range(99);
          if (r < 70) pd = $urandom_range(1, 2000);
          else if (r < 90) pd = $urandom_range(1, 200000);
        end
      end else if (r < 92) begin
        m = MODE_UNUSED;
      end else begin
        // noise: fully random fields; a non-tick code stays only with at most four free slots
        m = 2'($urandom_range(3));
        if (m != MODE_TICK && tbl_count < SLOTS - 4) m = MODE_TICK;
      end
      send_word(m, el, fd, pd, h);
    end
  endtask

  task automatic test_random_phases();
    run_phase(0,  16'd256, 40);
    run_phase(50, 16'($urandom_range(0, 16'hFFFF)), 40);
    run_phase(50, 16'd1, 30);
    run_phase(17, '1, 40);
    run_phase(0,  '0, 14);
    run_phase(17, 16'($urandom_range(16'h0100, 16'h4000)), 14);
  endtask

  // Reset, directed tests, random traffic, then the verdict
  initial begin
    time_scale_cfg = SCALE_RESET;
    tbl_count      = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_waited[i] = '0;
      tbl_first[i]  = '0;
      tbl_period[i] = '0;
      tbl_handle[i] = '0;
      tbl_flags[i]  = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_value();
    test_full_table();
    test_unused_mode();
    test_one_shot_period();
    test_close_up();
    test_saturating_wait();
    test_random_phases();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding_reports.size() == 0) begin
      $display("delayed_and_repeating_timer_table: match");
    end else begin
      $display("delayed_and_repeating_timer_table: mismatch");
    end
    $finish;
  end

endmodule
